### hdl/gha_pkg.sv
// Package for the generational handle allocator.
// Holds operation codes, status codes and the control state type.
// Depends on nothing.
package gha_pkg;

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_CHECK   = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

### hdl/generational_handle_allocator.sv
// Generational handle allocator: create, destroy and check of slot handles.
// Slot generations and the free stack live in two registered-read memories.
// Depends on gha_pkg.
//
//  channel  | direction | fields
//  s_axis   | in        | op, handle_index, handle_generation
//  m_axis   | out       | status, granted_index, granted_generation, live_total
//
// Each request is taken in S_IDLE, where the generation memory and the top of
// the free stack are read, and is decided and written back in S_EXEC. The next
// request can be taken in the cycle after the write back, not before. A
// finished result waits in the output register; the block holds the write
// back while that register is still full and not taken. Reset clears the
// counters and the control state, and the memories need no clearing pass.
module generational_handle_allocator #(
  parameter int SLOT_COUNT = 256,
  parameter int GEN_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // op[1:0], handle_index[9:2], handle_generation[25:10], zero fill above
  input  logic [gha_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[1:0], granted_index[9:2], granted_generation[25:10],
  // live_total[34:26], zero fill above
  output logic [gha_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [31:0] GEN_MASK = 32'((64'd1 << GEN_BITS) - 64'd1);

  logic [IDX_W+GEN_BITS-1:0] stk_mem [SLOT_COUNT];
  logic [GEN_BITS:0]         gen_mem [SLOT_COUNT];

  gha_pkg::state_t state, state_next;

  logic [1:0]          op;
  logic [7:0]          handle_index;
  logic [15:0]         handle_generation;
  logic [IDX_W+GEN_BITS-1:0] stk_rd;
  logic [GEN_BITS:0]   gen_rd;

  logic [CNT_W-1:0] free_depth;
  logic [CNT_W-1:0] high_water;
  logic [CNT_W-1:0] live_count;

  logic [1:0]          status;
  logic [7:0]          granted_index;
  logic [15:0]         granted_generation;
  logic [8:0]          live_total;

  logic accept;
  logic commit;
  logic handle_valid;
  logic gen_wr;
  logic [IDX_W-1:0]    gen_wr_addr;
  logic [GEN_BITS:0]   gen_wr_data;
  logic stk_push;
  logic stk_pop;
  logic hw_inc;
  logic live_inc;
  logic live_dec;
  logic [1:0]          status_next;
  logic [IDX_W-1:0]    slot_next;
  logic [GEN_BITS-1:0] gen_next;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      gha_pkg::S_IDLE: begin
        if (accept) begin
          state_next = gha_pkg::S_EXEC;
        end
      end
      gha_pkg::S_EXEC: begin
        if (commit) begin
          state_next = gha_pkg::S_IDLE;
        end
      end
      default: state_next = gha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    commit        = 1'b0;
    unique case (state)
      gha_pkg::S_IDLE: s_axis_tready = 1'b1;
      gha_pkg::S_EXEC: commit = !m_axis_tvalid || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
        commit        = 1'b0;
      end
    endcase
  end

  assign handle_valid = (32'(handle_index) < 32'(high_water)) &&
                        (32'(gen_rd[GEN_BITS-1:0]) == (32'(handle_generation) & GEN_MASK)) &&
                        gen_rd[GEN_BITS];

  always_comb begin
    status_next = gha_pkg::STAT_BAD;
    slot_next   = '0;
    gen_next    = '0;
    gen_wr      = 1'b0;
    gen_wr_addr = IDX_W'(handle_index);
    gen_wr_data = {1'b0, gen_rd[GEN_BITS-1:0]};
    stk_push    = 1'b0;
    stk_pop     = 1'b0;
    hw_inc      = 1'b0;
    live_inc    = 1'b0;
    live_dec    = 1'b0;
    case (op)
      gha_pkg::OP_CREATE: begin
        if (free_depth != '0) begin
          slot_next   = stk_rd[IDX_W+GEN_BITS-1:GEN_BITS];
          gen_next    = stk_rd[GEN_BITS-1:0] + GEN_BITS'(1);
          stk_pop     = 1'b1;
          status_next = gha_pkg::STAT_OK;
        end else if (high_water < CNT_W'(SLOT_COUNT)) begin
          slot_next   = IDX_W'(high_water);
          gen_next    = '0;
          hw_inc      = 1'b1;
          status_next = gha_pkg::STAT_OK;
        end else begin
          status_next = gha_pkg::STAT_FULL;
        end
        if (status_next == gha_pkg::STAT_OK) begin
          gen_wr      = 1'b1;
          gen_wr_addr = slot_next;
          gen_wr_data = {1'b1, gen_next};
          live_inc    = 1'b1;
        end
      end
      gha_pkg::OP_DESTROY: begin
        if (handle_valid) begin
          gen_wr      = 1'b1;
          stk_push    = free_depth < CNT_W'(SLOT_COUNT);
          live_dec    = live_count != '0;
          status_next = gha_pkg::STAT_OK;
        end
      end
      gha_pkg::OP_CHECK: begin
        status_next = handle_valid ? gha_pkg::STAT_OK : gha_pkg::STAT_BAD;
      end
      default: status_next = gha_pkg::STAT_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op                <= s_axis_tdata[1:0];
      handle_index      <= s_axis_tdata[9:2];
      handle_generation <= s_axis_tdata[25:10];
      stk_rd            <= stk_mem[IDX_W'(free_depth - CNT_W'(1))];
      gen_rd            <= gen_mem[IDX_W'(s_axis_tdata[9:2])];
    end
    if (commit && gen_wr) begin
      gen_mem[gen_wr_addr] <= gen_wr_data;
    end
    if (commit && stk_push) begin
      stk_mem[IDX_W'(free_depth)] <= {IDX_W'(handle_index), gen_rd[GEN_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gha_pkg::S_IDLE;
      free_depth    <= '0;
      high_water    <= '0;
      live_count    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (commit) begin
        if (stk_pop) begin
          free_depth <= free_depth - CNT_W'(1);
        end else if (stk_push) begin
          free_depth <= free_depth + CNT_W'(1);
        end
        if (hw_inc) begin
          high_water <= high_water + CNT_W'(1);
        end
        if (live_inc) begin
          live_count <= live_count + CNT_W'(1);
        end else if (live_dec) begin
          live_count <= live_count - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status             <= status_next;
      granted_index      <= (status_next == gha_pkg::STAT_OK && op == gha_pkg::OP_CREATE) ?
                            8'(slot_next) : 8'd0;
      granted_generation <= 16'(32'(gen_next));
      live_total         <= 9'(live_inc ? live_count + CNT_W'(1) :
                               live_dec ? live_count - CNT_W'(1) : live_count);
    end
  end

  assign m_axis_tdata = {5'd0, live_total, granted_generation, granted_index, status};

endmodule
